[design/tcp_segment_reorder_buffer_assert.svh]
// ----------------------------------------------------------------------------
// tcp segment reorder buffer assertion macros
// shared concurrent assertion helpers, clocked on clk_i, quiet in reset
// ----------------------------------------------------------------------------
`ifndef TCP_SEGMENT_REORDER_BUFFER_ASSERT_SVH
`define TCP_SEGMENT_REORDER_BUFFER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define TSRB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition must never be true out of reset
`define TSRB_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`else

`define TSRB_ASSERT(lbl, prop)
`define TSRB_ASSERT_NEVER(lbl, cond)

`endif

`endif

[design/tsrb_pkg.sv]
// ----------------------------------------------------------------------------
// tsrb_pkg
// shared sizes and beat types of the tcp segment reorder buffer
// ----------------------------------------------------------------------------
`default_nettype none

package tsrb_pkg;

  localparam int unsigned FLOWS     = 1024;
  localparam int unsigned BUF_SLOTS = 16;
  localparam int unsigned FLOW_W    = (FLOWS > 1) ? $clog2(FLOWS) : 1;
  localparam int unsigned SLOT_W    = (BUF_SLOTS > 1) ? $clog2(BUF_SLOTS) : 1;
  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned ROW_W     = SEQ_W * BUF_SLOTS;
  localparam int unsigned FREC_W    = SEQ_W + 1;

  // input beat
  typedef struct packed {
    logic [9:0]       flow_slot;
    logic [SEQ_W-1:0] seq_number;
    logic             has_payload;
  } item_t;

  // result beat
  typedef struct packed {
    logic [CNT_W-1:0] released_count;
    logic             was_buffered;
    logic             buffer_full;
    logic [KEY_W-1:0] storage_key;
    logic [SEQ_W-1:0] expected_after;
  } result_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [9:0]       flow_slot;
    logic [SEQ_W-1:0] seq_number;
    logic             in_range;
    logic             is_data;
  } cmd_t;

  // per-flow record held in the flow memory
  typedef struct packed {
    logic             known;
    logic [SEQ_W-1:0] expected;
  } flow_rec_t;

endpackage

`default_nettype wire

[design/tsrb_ram.sv]
// ----------------------------------------------------------------------------
// tsrb_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tsrb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[design/tsrb_front.sv]
// ----------------------------------------------------------------------------
// tsrb_front
// accepts input beats, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module tsrb_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  input  wire tsrb_pkg::item_t item_i,
  output logic                 full,
  output logic                 cmd_valid_o,
  output tsrb_pkg::cmd_t       cmd_o,
  input  wire logic            cmd_take_i
);

  tsrb_pkg::cmd_t cmd_q [2];
  logic           wr_q, wr_d;
  logic           rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           accept;
  tsrb_pkg::cmd_t cls;

  // classify: range check and no-operation detection
  always_comb begin
    cls.flow_slot  = item_i.flow_slot;
    cls.seq_number = item_i.seq_number;
    cls.in_range   = 32'(item_i.flow_slot) < 32'(tsrb_pkg::FLOWS);
    cls.is_data    = item_i.has_payload && (item_i.seq_number != '0);
  end

  assign full        = (cnt_q == 2'd2);
  assign accept      = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = cmd_q[rd_q];

  // queue pointers
  always_comb begin
    wr_d  = accept ? ~wr_q : wr_q;
    rd_d  = cmd_take_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(accept) - 2'(cmd_take_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q[wr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

[design/tsrb_back.sv]
// ----------------------------------------------------------------------------
// tsrb_back
// per-flow lookup, buffering and drain engine with a two-beat result queue
// ----------------------------------------------------------------------------
`default_nettype none

`include "tcp_segment_reorder_buffer_assert.svh"

module tsrb_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire tsrb_pkg::cmd_t cmd_i,
  output logic                cmd_take_o,
  output logic                empty,
  input  wire logic           pop,
  output tsrb_pkg::result_t   result_o
);

  localparam int unsigned FW = tsrb_pkg::FLOW_W;
  localparam int unsigned SW = tsrb_pkg::SEQ_W;
  localparam int unsigned NS = tsrb_pkg::BUF_SLOTS;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_DRAIN} state_e;
  typedef logic [NS-1:0][SW-1:0] row_t;

  state_e               state_q, state_d;
  logic [FW-1:0]        clr_q, clr_d;
  tsrb_pkg::cmd_t       cmd_q, cmd_d;
  logic [SW-1:0]        exp_q, exp_d;
  row_t                 row_q, row_d;
  logic [tsrb_pkg::CNT_W-1:0] rel_q, rel_d;
  logic [tsrb_pkg::KEY_W-1:0] key_q, key_d;
  logic [tsrb_pkg::KEY_W-1:0] key_use;

  // memories
  logic                 flow_we, slot_we;
  logic [FW-1:0]        flow_waddr, flow_raddr;
  tsrb_pkg::flow_rec_t  flow_wdata, flow_rdata;
  row_t                 slot_wdata, slot_rdata;

  // lookup helpers
  logic                 known;
  logic [SW-1:0]        exp_eff;
  row_t                 row_eff, row_ins;
  logic                 free_found, hit_found;
  logic [tsrb_pkg::SLOT_W-1:0] free_idx, hit_idx;

  // result queue
  tsrb_pkg::result_t    oq_q [2];
  logic                 oq_wr_q, oq_rd_q;
  logic [1:0]           oq_cnt_q;
  logic                 res_push, res_pop;
  tsrb_pkg::result_t    res;

  tsrb_ram #(.WIDTH(tsrb_pkg::FREC_W), .DEPTH(tsrb_pkg::FLOWS)) u_flow_ram (
    .clk_i   (clk_i),
    .we_i    (flow_we),
    .waddr_i (flow_waddr),
    .wdata_i (flow_wdata),
    .raddr_i (flow_raddr),
    .rdata_o (flow_rdata)
  );

  tsrb_ram #(.WIDTH(tsrb_pkg::ROW_W), .DEPTH(tsrb_pkg::FLOWS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (flow_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (flow_raddr),
    .rdata_o (slot_rdata)
  );

  // effective flow view, a new flow starts at one with an empty row
  assign known   = flow_rdata.known;
  assign exp_eff = known ? flow_rdata.expected : SW'(1);
  assign row_eff = known ? slot_rdata : '0;

  // lowest empty slot of the looked-up row
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (row_eff[i] == '0) begin
        free_found = 1'b1;
        free_idx   = tsrb_pkg::SLOT_W'(i);
      end
    end
  end

  // lowest slot matching the running expected number
  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (row_q[i] == exp_q) begin
        hit_found = 1'b1;
        hit_idx   = tsrb_pkg::SLOT_W'(i);
      end
    end
  end

  // row with the new segment inserted, and key with zero skipped
  always_comb begin
    row_ins           = row_eff;
    row_ins[free_idx] = cmd_q.seq_number;
  end
  assign key_use = (key_q == '0) ? tsrb_pkg::KEY_W'(1) : key_q;

  // engine sequencing
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cmd_d      = cmd_q;
    exp_d      = exp_q;
    row_d      = row_q;
    rel_d      = rel_q;
    key_d      = key_q;
    cmd_take_o = 1'b0;
    flow_we    = 1'b0;
    slot_we    = 1'b0;
    flow_waddr = FW'(cmd_q.flow_slot);
    flow_raddr = FW'(cmd_i.flow_slot);
    flow_wdata = '0;
    slot_wdata = row_q;
    res_push   = 1'b0;
    res        = '0;
    unique case (state_q)
      S_CLEAR: begin
        flow_we    = 1'b1;
        flow_waddr = clr_q;
        clr_d      = clr_q + FW'(1);
        if (clr_q == FW'(tsrb_pkg::FLOWS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i && (oq_cnt_q != 2'd2)) begin
          cmd_take_o = 1'b1;
          cmd_d      = cmd_i;
          state_d    = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!cmd_q.in_range) begin
          res_push = 1'b1;
          state_d  = S_IDLE;
        end else if (!cmd_q.is_data) begin
          res.expected_after = known ? flow_rdata.expected : '0;
          res_push           = 1'b1;
          state_d            = S_IDLE;
        end else if (cmd_q.seq_number == exp_eff) begin
          exp_d   = exp_eff + SW'(1);
          row_d   = row_eff;
          rel_d   = tsrb_pkg::CNT_W'(1);
          state_d = S_DRAIN;
        end else begin
          flow_we            = 1'b1;
          flow_wdata         = '{known: 1'b1, expected: exp_eff};
          slot_we            = 1'b1;
          slot_wdata         = row_eff;
          res.expected_after = exp_eff;
          res_push           = 1'b1;
          state_d            = S_IDLE;
          if (free_found) begin
            slot_wdata       = row_ins;
            res.was_buffered = 1'b1;
            res.storage_key  = key_use;
            key_d            = key_use + tsrb_pkg::KEY_W'(1);
          end else begin
            res.buffer_full = 1'b1;
          end
        end
      end
      S_DRAIN: begin
        if ((exp_q != '0) && hit_found) begin
          row_d[hit_idx] = '0;
          exp_d          = exp_q + SW'(1);
          rel_d          = (rel_q == '1) ? rel_q : rel_q + tsrb_pkg::CNT_W'(1);
        end else begin
          flow_we            = 1'b1;
          flow_wdata         = '{known: 1'b1, expected: exp_q};
          slot_we            = 1'b1;
          slot_wdata         = row_q;
          res.released_count = rel_q;
          res.expected_after = exp_q;
          res_push           = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      key_q   <= tsrb_pkg::KEY_W'(1);
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      key_q   <= key_d;
    end
  end

  // working registers of the item in flight
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    exp_q <= exp_d;
    row_q <= row_d;
    rel_q <= rel_d;
  end

  // result queue
  assign res_pop  = pop && !empty;
  assign empty    = (oq_cnt_q == 2'd0);
  assign result_o = oq_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      if (res_push) begin
        oq_wr_q <= ~oq_wr_q;
      end
      if (res_pop) begin
        oq_rd_q <= ~oq_rd_q;
      end
      oq_cnt_q <= oq_cnt_q + 2'(res_push) - 2'(res_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      oq_q[oq_wr_q] <= res;
    end
  end

  // checks
  `TSRB_ASSERT_NEVER(a_oq_overflow, oq_cnt_q == 2'd2 && res_push && !res_pop)
  `TSRB_ASSERT(a_take_to_look, cmd_take_o |=> state_q == S_LOOK)
  `TSRB_ASSERT(a_push_state, res_push |-> state_q == S_LOOK || state_q == S_DRAIN)
  `TSRB_ASSERT_NEVER(a_write_clash, flow_we && state_q == S_IDLE)

endmodule

`default_nettype wire

[design/tcp_segment_reorder_buffer.sv]
// ----------------------------------------------------------------------------
// tcp_segment_reorder_buffer
// per-flow segment reorder tracker: classify front, queue, drain back end
// ----------------------------------------------------------------------------
// channel   direction  handshake            beat
// input     in         push / full          item_i   (tsrb_pkg::item_t)
// result    out        pop / empty          result_o (tsrb_pkg::result_t)
//
// in the back end an item is taken and looked up; an in-order segment then
// moves to the drain state, which releases the buffered segments that follow
// it in the per-flow slot row (up to BUF_SLOTS) and then writes the flow back.
// after reset the flow memory is swept, one flow per cycle, over all FLOWS
// (1024) entries; beats are queued by the front but not worked on meanwhile.
// a two-beat result queue lets the engine finish while pop is held low;
// the engine waits in idle while both result queue entries are held.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_segment_reorder_buffer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  input  wire tsrb_pkg::item_t   item_i,
  output logic                   full,
  output logic                   empty,
  input  wire logic              pop,
  output tsrb_pkg::result_t      result_o
);

  logic           cmd_valid;
  logic           cmd_take;
  tsrb_pkg::cmd_t cmd;

  tsrb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .item_i      (item_i),
    .full        (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  tsrb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire
